/* sv/utt_pkg.sv */
// Shared types, constants and helper functions of the UTF-8 trigram tokenizer.
package utt_pkg;

  // Width of the saturating token counter.
  localparam int INDEX_BITS = 16;
  // Width of the token_index field.
  localparam int TOK_W = 16;
  // Configuration port geometry.
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  // Depth of the queue between classifier and emitter.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CJK_LOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CJK_HIGH = CFG_IDX_W'(1);

  // Reset values of the CJK range registers.
  localparam logic [CFG_W-1:0] CJK_LOW_RESET = 16'h4E00;
  localparam logic [CFG_W-1:0] CJK_HIGH_RESET = 16'h9FFF;

  // Padding character around words.
  localparam logic [7:0] PAD_CHAR = 8'h23;

  // UTF-8 code point limits for a valid three-byte character.
  localparam logic [15:0] CP_MIN_3B = 16'h0800;
  localparam logic [15:0] SURR_LOW = 16'hD800;
  localparam logic [15:0] SURR_HIGH = 16'hDFFF;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_TRIGRAM = 2'd0,
    KIND_CJK     = 2'd1,
    KIND_MARKER  = 2'd2
  } kind_t;

  // One result beat, without its last flag.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [TOK_W-1:0] index;
  } result_t;

  // All results caused by one input byte, in order; count is 1 to 3.
  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    count;
  } bundle_t;

  // Build a result from its parts.
  function automatic result_t make_tok(kind_t k, logic [7:0] x0, logic [7:0] x1,
                                       logic [7:0] x2, logic [INDEX_BITS-1:0] idx);
    result_t r;
    r.kind = k;
    r.b0 = x0;
    r.b1 = x1;
    r.b2 = x2;
    r.index = TOK_W'(idx);
    return r;
  endfunction

  // Counter increment that sticks at the all-ones value.
  function automatic logic [INDEX_BITS-1:0] sat_inc(logic [INDEX_BITS-1:0] v);
    return (&v) ? v : v + INDEX_BITS'(1);
  endfunction

endpackage

/* sv/utt_in_if.sv */
// Input byte channel of the tokenizer.
interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_query;

  modport source (output valid, output in_byte, output end_of_query, input ready);
  modport sink (input valid, input in_byte, input end_of_query, output ready);
endinterface

/* sv/utt_out_if.sv */
// Result token channel of the tokenizer.
interface utt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tok_byte0;
  logic [7:0]  tok_byte1;
  logic [7:0]  tok_byte2;
  logic [15:0] token_index;
  logic        last_of_item;

  modport source (output valid, output kind, output tok_byte0, output tok_byte1,
                  output tok_byte2, output token_index, output last_of_item, input ready);
  modport sink (input valid, input kind, input tok_byte0, input tok_byte1,
                input tok_byte2, input token_index, input last_of_item, output ready);
endinterface

/* sv/utt_front.sv */
// Front end: byte classification, UTF-8 decoding, word history and token counting.
module utt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [utt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [utt_pkg::CFG_W-1:0]      cfg_data,
  utt_in_if.sink                         in_ch,
  input  logic                           q_full,
  output logic                           q_push,
  output utt_pkg::bundle_t               q_data
);
  import utt_pkg::*;

  // Configuration and tokenizer state.
  logic [CFG_W-1:0]      cjk_low;
  logic [CFG_W-1:0]      cjk_high;
  logic [7:0]            h1, h1_next;
  logic [7:0]            h2, h2_next;
  logic [1:0]            wl, wl_next;
  logic [1:0]            left, left_next;
  logic [15:0]           code, code_next;
  logic                  is3, is3_next;
  logic                  cont_ok, cont_ok_next;
  logic [INDEX_BITS-1:0] cnt, cnt_next;

  logic [7:0] b;
  logic       eoq;
  logic       accept;
  logic       is_upper;
  logic       is_alnum;
  logic [7:0] lc;
  logic       tok_a_v;
  logic       tok_b_v;
  result_t    tok_a;
  result_t    tok_b;
  result_t    mark;
  logic [1:0] k;

  assign b = in_ch.in_byte;
  assign eoq = in_ch.end_of_query;
  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;

  // Character classes and lowercasing.
  assign is_upper = (b >= 8'h41) && (b <= 8'h5A);
  assign is_alnum = ((b >= 8'h30) && (b <= 8'h39)) || is_upper ||
                    ((b >= 8'h61) && (b <= 8'h7A));
  assign lc = is_upper ? b + 8'h20 : b;

  // Next state and the results of one byte.
  always_comb begin
    h1_next = h1;
    h2_next = h2;
    wl_next = wl;
    left_next = left;
    code_next = code;
    is3_next = is3;
    cont_ok_next = cont_ok;
    cnt_next = cnt;
    tok_a_v = 1'b0;
    tok_a = '0;
    tok_b_v = 1'b0;
    tok_b = '0;
    mark = '0;

    if (left != 2'd0) begin
      // Continuation byte of an open multibyte character.
      if (b[7:6] != 2'b10) begin
        cont_ok_next = 1'b0;
      end
      code_next = {code[9:0], b[5:0]};
      left_next = left - 2'd1;
      if (left_next == 2'd0) begin
        if (is3 && cont_ok_next && (code_next >= CP_MIN_3B) &&
            !((code_next >= SURR_LOW) && (code_next <= SURR_HIGH)) &&
            (code_next >= cjk_low) && (code_next <= cjk_high)) begin
          tok_a_v = 1'b1;
          tok_a = make_tok(KIND_CJK, {4'hE, code_next[15:12]},
                           {2'b10, code_next[11:6]}, {2'b10, code_next[5:0]}, cnt);
        end
        is3_next = 1'b0;
        code_next = '0;
      end
    end else if (!b[7]) begin
      if (is_alnum) begin
        // Extend the word and emit a trigram once two characters are known.
        case (wl)
          2'd0: begin
            wl_next = 2'd1;
          end
          2'd1: begin
            tok_a_v = 1'b1;
            tok_a = make_tok(KIND_TRIGRAM, PAD_CHAR, h1, lc, cnt);
            wl_next = 2'd2;
          end
          default: begin
            tok_a_v = 1'b1;
            tok_a = make_tok(KIND_TRIGRAM, h2, h1, lc, cnt);
          end
        endcase
        h2_next = h1;
        h1_next = lc;
      end else begin
        // Any other ASCII byte closes the word.
        if (wl == 2'd1) begin
          tok_a_v = 1'b1;
          tok_a = make_tok(KIND_TRIGRAM, PAD_CHAR, h1, PAD_CHAR, cnt);
        end else if (wl != 2'd0) begin
          tok_a_v = 1'b1;
          tok_a = make_tok(KIND_TRIGRAM, h2, h1, PAD_CHAR, cnt);
        end
        wl_next = 2'd0;
        h1_next = '0;
        h2_next = '0;
      end
    end else begin
      // A byte with the top bit set closes the word and may open a character.
      if (wl == 2'd1) begin
        tok_a_v = 1'b1;
        tok_a = make_tok(KIND_TRIGRAM, PAD_CHAR, h1, PAD_CHAR, cnt);
      end else if (wl != 2'd0) begin
        tok_a_v = 1'b1;
        tok_a = make_tok(KIND_TRIGRAM, h2, h1, PAD_CHAR, cnt);
      end
      wl_next = 2'd0;
      h1_next = '0;
      h2_next = '0;
      cont_ok_next = 1'b1;
      is3_next = 1'b0;
      code_next = '0;
      if (b[7:5] == 3'b110) begin
        left_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        left_next = 2'd2;
        is3_next = 1'b1;
        code_next = {12'h000, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        left_next = 2'd3;
      end
    end

    if (tok_a_v) begin
      cnt_next = sat_inc(cnt);
    end

    if (eoq) begin
      // End of query: close the word, drop a partial character, emit the marker.
      if (wl_next == 2'd1) begin
        tok_b_v = 1'b1;
        tok_b = make_tok(KIND_TRIGRAM, PAD_CHAR, h1_next, PAD_CHAR, cnt_next);
      end else if (wl_next != 2'd0) begin
        tok_b_v = 1'b1;
        tok_b = make_tok(KIND_TRIGRAM, h2_next, h1_next, PAD_CHAR, cnt_next);
      end
      if (tok_b_v) begin
        cnt_next = sat_inc(cnt_next);
      end
      mark = make_tok(KIND_MARKER, 8'h00, 8'h00, 8'h00, cnt_next);
      wl_next = 2'd0;
      h1_next = '0;
      h2_next = '0;
      left_next = 2'd0;
      code_next = '0;
      is3_next = 1'b0;
      cont_ok_next = 1'b0;
      cnt_next = '0;
    end
  end

  // Pack the results of this byte into consecutive slots.
  always_comb begin
    q_data = '0;
    k = 2'd0;
    if (tok_a_v) begin
      q_data.res[k] = tok_a;
      k = k + 2'd1;
    end
    if (tok_b_v) begin
      q_data.res[k] = tok_b;
      k = k + 2'd1;
    end
    if (eoq) begin
      q_data.res[k] = mark;
      k = k + 2'd1;
    end
    q_data.count = k;
  end

  assign q_push = accept && (k != 2'd0);

  // State registers and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cjk_low <= CJK_LOW_RESET;
      cjk_high <= CJK_HIGH_RESET;
      h1 <= '0;
      h2 <= '0;
      wl <= '0;
      left <= '0;
      code <= '0;
      is3 <= 1'b0;
      cont_ok <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_wr_en && (cfg_index == CFG_CJK_LOW)) begin
        cjk_low <= cfg_data;
      end
      if (cfg_wr_en && (cfg_index == CFG_CJK_HIGH)) begin
        cjk_high <= cfg_data;
      end
      if (accept) begin
        h1 <= h1_next;
        h2 <= h2_next;
        wl <= wl_next;
        left <= left_next;
        code <= code_next;
        is3 <= is3_next;
        cont_ok <= cont_ok_next;
        cnt <= cnt_next;
      end
    end
  end

endmodule

/* sv/utt_queue.sv */
// Short queue of result bundles between the front end and the emitter.
module utt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utt_pkg::bundle_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output utt_pkg::bundle_t head
);
  import utt_pkg::*;

  bundle_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];
  assign do_pop = pop && not_empty;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* sv/utt_back.sv */
// Back end: walks each queued bundle and drives one result beat per cycle while the sink is ready.
module utt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  utt_pkg::bundle_t q_head,
  output logic             q_pop,
  utt_out_if.source        out_ch
);
  import utt_pkg::*;

  logic       out_valid;
  result_t    out_res;
  logic       out_last;
  logic [1:0] sel;
  logic       load;
  logic       sel_last;

  assign load = !out_valid || out_ch.ready;
  assign sel_last = (sel == q_head.count - 2'd1);
  assign q_pop = load && q_not_empty && sel_last;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel <= '0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        sel <= sel_last ? 2'd0 : sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_not_empty) begin
      out_res <= q_head.res[sel];
      out_last <= sel_last;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.kind = out_res.kind;
  assign out_ch.tok_byte0 = out_res.b0;
  assign out_ch.tok_byte1 = out_res.b1;
  assign out_ch.tok_byte2 = out_res.b2;
  assign out_ch.token_index = out_res.index;
  assign out_ch.last_of_item = out_last;

endmodule

/* sv/utf8_cjk_and_letter_trigram_tokenizer_core.sv */
// The first result of a byte is written into the bundle queue when the byte is accepted, then
// loaded into the output register that drives it; a stalled sink can hold it in the queue.
// Throughput: one byte per cycle while the four-entry bundle queue has room; a byte that
// yields k results (k up to 3) sends them in turn through the single output register.
// Reset (synchronous, active high) clears the decoder, word history, token counter and
// queue, and returns the CJK range registers to 0x4E00..0x9FFF.
module utf8_cjk_and_letter_trigram_tokenizer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [utt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [utt_pkg::CFG_W-1:0]     cfg_data,
  utt_in_if.sink                        in_ch,
  utt_out_if.source                     out_ch
);
  import utt_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_not_empty;
  bundle_t q_in;
  bundle_t q_head;

  // Classifier and decoder.
  utt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Bundle queue.
  utt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Result emitter.
  utt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("bundle pushed into a full queue");

  // Every queued bundle carries at least one result.
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_not_empty |-> (q_head.count != 2'd0))
    else $error("empty bundle in queue");

  // The end-of-query marker is always the final result of its byte.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.kind == KIND_MARKER)) |-> out_ch.last_of_item)
    else $error("marker not flagged as last result");

endmodule

/* tb/sv/utf8_cjk_and_letter_trigram_tokenizer_core_test.sv */
// Self-checking testbench for the UTF-8 letter-trigram and CJK tokenizer core.
module utf8_cjk_and_letter_trigram_tokenizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 32;

  // Register indexes with no register behind them; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = CFG_IDX_W'(3);

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    ROW_PRED,   // expected tokens come from the predictor
    ROW_NONE,   // byte must produce no token
    ROW_ONE,    // byte must produce exactly the typed token
    ROW_CFG     // register write, done while the block is idle
  } row_op_t;

  typedef struct packed {
    result_t r;
    logic    last_flag;
  } tok_t;

  typedef struct {
    row_op_t              op;
    logic [7:0]           b;
    logic                 eoq;
    result_t              r;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  utt_in_if  in_ch ();
  utt_out_if out_ch ();

  utf8_cjk_and_letter_trigram_tokenizer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // Tokenizer state as the predictor sees it.
  logic [7:0]            w_new = '0;
  logic [7:0]            w_old = '0;
  logic [1:0]            w_len = '0;
  logic [1:0]            mb_left = '0;
  logic [15:0]           mb_code = '0;
  logic                  mb_three = 1'b0;
  logic                  mb_ok = 1'b0;
  logic [INDEX_BITS-1:0] tok_count = '0;
  logic [CFG_W-1:0]      range_lo = CJK_LOW_RESET;
  logic [CFG_W-1:0]      range_hi = CJK_HIGH_RESET;

  tok_t       step_toks[$];
  tok_t       pending_tokens[$];
  stim_row_t  dir_tab[$];
  logic [7:0] q_bytes[$];

  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left = 0;
  bit   hold_req = 1'b0;
  tok_t got_tok;
  tok_t want_tok;

  function automatic result_t tk(kind_t k, logic [7:0] x0, logic [7:0] x1, logic [7:0] x2,
                                 logic [TOK_W-1:0] idx);
    result_t r;
    r.kind = k;
    r.b0 = x0;
    r.b1 = x1;
    r.b2 = x2;
    r.index = idx;
    return r;
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic void add_tok(kind_t k, logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
    tok_t t;
    t.r = tk(k, x0, x1, x2, TOK_W'(tok_count));
    t.last_flag = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  // A counted token takes the current index, then the count moves on unless it is full.
  function automatic void count_tok(kind_t k, logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
    add_tok(k, x0, x1, x2);
    if (tok_count != '1) tok_count = tok_count + 1'b1;
  endfunction

  // Closing an open word emits its last trigram with the trailing pad.
  function automatic void close_word();
    if (w_len == 2'd1) count_tok(KIND_TRIGRAM, PAD_CHAR, w_new, PAD_CHAR);
    else if (w_len >= 2'd2) count_tok(KIND_TRIGRAM, w_old, w_new, PAD_CHAR);
    w_len = '0;
    w_new = '0;
    w_old = '0;
  endfunction

  // Works out every token that one accepted byte causes, into step_toks.
  function automatic void tokenize_byte(logic [7:0] b, logic eoq);
    logic [7:0]  c;
    logic [15:0] cp;
    step_toks.delete();
    if (mb_left != 2'd0) begin
      // Bytes after a lead byte are swallowed whatever they hold.
      if (b[7:6] != 2'b10) mb_ok = 1'b0;
      mb_code = {mb_code[9:0], b[5:0]};
      mb_left = mb_left - 2'd1;
      if (mb_left == 2'd0) begin
        cp = mb_code;
        if (mb_three && mb_ok && cp >= CP_MIN_3B && !(cp >= SURR_LOW && cp <= SURR_HIGH) &&
            cp >= range_lo && cp <= range_hi)
          count_tok(KIND_CJK, {4'hE, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]});
        mb_three = 1'b0;
        mb_code = '0;
      end
    end else if (!b[7]) begin
      if (is_word_char(b)) begin
        c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        case (w_len)
          2'd0: w_len = 2'd1;
          2'd1: begin
            count_tok(KIND_TRIGRAM, PAD_CHAR, w_new, c);
            w_len = 2'd2;
          end
          default: count_tok(KIND_TRIGRAM, w_old, w_new, c);
        endcase
        w_old = w_new;
        w_new = c;
      end else begin
        close_word();
      end
    end else begin
      // Lead byte, stray continuation or invalid byte: the word ends here.
      close_word();
      mb_ok = 1'b1;
      mb_three = 1'b0;
      mb_code = '0;
      if (b[7:5] == 3'b110) begin
        mb_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        mb_left = 2'd2;
        mb_three = 1'b1;
        mb_code = {12'h000, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        mb_left = 2'd3;
      end
    end

    // End of query: drop a partial character, emit the count, start over.
    if (eoq) begin
      close_word();
      mb_left = '0;
      mb_code = '0;
      mb_three = 1'b0;
      mb_ok = 1'b0;
      add_tok(KIND_MARKER, 8'h00, 8'h00, 8'h00);
      tok_count = '0;
    end
    if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last_flag = 1'b1;
  endfunction

  function automatic void add_byte_row(row_op_t op, logic [7:0] b, logic eoq,
                                       result_t r = '0);
    stim_row_t row;
    row.op = op;
    row.b = b;
    row.eoq = eoq;
    row.r = r;
    row.reg_idx = '0;
    row.reg_val = '0;
    dir_tab = {dir_tab, row};
  endfunction

  function automatic void add_cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row.op = ROW_CFG;
    row.b = '0;
    row.eoq = 1'b0;
    row.r = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_tab = {dir_tab, row};
  endfunction

  // Appends one byte to the query under construction.
  function automatic void put_byte(logic [7:0] v);
    q_bytes = {q_bytes, v};
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(2))
      0: return 8'h30 + 8'($urandom_range(9));
      1: return 8'h41 + 8'($urandom_range(25));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Offers one byte, waits for its beat, then records what it should cause.
  task automatic push_byte(row_op_t op, logic [7:0] b, logic eoq, result_t typed);
    tok_t t;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_query <= eoq;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tokenize_byte(b, eoq);
    case (op)
      ROW_PRED: foreach (step_toks[i]) pending_tokens = {pending_tokens, step_toks[i]};
      ROW_ONE: begin
        t.r = typed;
        t.last_flag = 1'b1;
        pending_tokens = {pending_tokens, t};
      end
      default: ;
    endcase
  endtask

  // Stops sending and waits until every expected token has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CJK_LOW) range_lo = val;
    else if (idx == CFG_CJK_HIGH) range_hi = val;
  endtask

  // Builds one query from words, CJK characters, other UTF-8 sequences and noise.
  task automatic build_query();
    int          n;
    logic [15:0] cp;
    q_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 4);
          repeat (n) put_byte(word_char());
        end
        4, 5: begin
          n = $urandom_range(9);
          if (n < 4 && range_lo <= range_hi) begin
            cp = range_lo + 16'($urandom_range(range_hi - range_lo));
          end else if (n < 6) begin
            case ($urandom_range(9))
              0: cp = range_lo;
              1: cp = range_hi;
              2: cp = range_lo - 16'd1;
              3: cp = range_hi + 16'd1;
              4: cp = CP_MIN_3B;
              5: cp = CP_MIN_3B - 16'd1;
              6: cp = SURR_LOW;
              7: cp = SURR_HIGH;
              8: cp = SURR_LOW - 16'd1;
              default: cp = SURR_HIGH + 16'd1;
            endcase
          end else begin
            cp = 16'($urandom);
          end
          put_byte({4'hE, cp[15:12]});
          put_byte({2'b10, cp[11:6]});
          put_byte({2'b10, cp[5:0]});
          // Now and then a continuation byte is broken.
          if ($urandom_range(9) == 0)
            q_bytes[q_bytes.size() - 1 - $urandom_range(1)] = 8'($urandom);
        end
        6: begin
          if ($urandom_range(1) == 0) begin
            case ($urandom_range(7))
              0: put_byte(8'h2F);
              1: put_byte(8'h3A);
              2: put_byte(8'h40);
              3: put_byte(8'h5B);
              4: put_byte(8'h60);
              5: put_byte(8'h7B);
              6: put_byte(8'h7F);
              default: put_byte(8'h20);
            endcase
          end else begin
            do cp = 16'($urandom_range(127)); while (is_word_char(cp[7:0]));
            put_byte(cp[7:0]);
          end
        end
        7: begin
          put_byte({3'b110, 5'($urandom)});
          put_byte({2'b10, 6'($urandom)});
        end
        8: begin
          put_byte({5'b11110, 3'($urandom)});
          repeat (3) put_byte({2'b10, 6'($urandom)});
        end
        default: put_byte(8'($urandom));
      endcase
    end
    // Some queries end inside a character.
    if (q_bytes.size() > 1 && $urandom_range(99) < 15) void'(q_bytes.pop_back());
  endtask

  task automatic run_queries(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      build_query();
      foreach (q_bytes[i]) push_byte(ROW_PRED, q_bytes[i], i == q_bytes.size() - 1, '0);
      sent += q_bytes.size();
    end
  endtask

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each token beat is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_tok.r = tk(kind_t'(out_ch.kind), out_ch.tok_byte0, out_ch.tok_byte1,
                     out_ch.tok_byte2, out_ch.token_index);
      got_tok.last_flag = out_ch.last_of_item;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t ns: token expected none, got %h", $time, got_tok);
      end else begin
        want_tok = pending_tokens.pop_front();
        check_field("kind", 16'(want_tok.r.kind), 16'(got_tok.r.kind));
        check_field("tok_byte0", 16'(want_tok.r.b0), 16'(got_tok.r.b0));
        check_field("tok_byte1", 16'(want_tok.r.b1), 16'(got_tok.r.b1));
        check_field("tok_byte2", 16'(want_tok.r.b2), 16'(got_tok.r.b2));
        check_field("token_index", want_tok.r.index, got_tok.r.index);
        check_field("last_of_item", 16'(want_tok.last_flag), 16'(got_tok.last_flag));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.end_of_query = 1'b0;
    out_ch.ready = 1'b0;

    // Empty query straight after reset, then a mixed-case word with a digit.
    add_byte_row(ROW_ONE, 8'h00, 1'b1, tk(KIND_MARKER, 8'h00, 8'h00, 8'h00, 16'd0));
    add_byte_row(ROW_NONE, 8'h41, 1'b0);
    add_byte_row(ROW_ONE, 8'h62, 1'b0, tk(KIND_TRIGRAM, PAD_CHAR, 8'h61, 8'h62, 16'd0));
    add_byte_row(ROW_PRED, 8'h5A, 1'b0);
    add_byte_row(ROW_PRED, 8'h39, 1'b1);
    // Lowest and highest code points of the default range.
    add_byte_row(ROW_NONE, 8'hE4, 1'b0);
    add_byte_row(ROW_NONE, 8'hB8, 1'b0);
    add_byte_row(ROW_ONE, 8'h80, 1'b0, tk(KIND_CJK, 8'hE4, 8'hB8, 8'h80, 16'd0));
    add_byte_row(ROW_PRED, 8'hE9, 1'b0);
    add_byte_row(ROW_PRED, 8'hBF, 1'b0);
    add_byte_row(ROW_PRED, 8'hBF, 1'b0);
    // One-letter word closed by a two-byte lead, then its swallowed tail.
    add_byte_row(ROW_PRED, 8'h30, 1'b0);
    add_byte_row(ROW_PRED, 8'hC3, 1'b0);
    add_byte_row(ROW_PRED, 8'hA9, 1'b0);
    // Invalid lead and stray continuation byte.
    add_byte_row(ROW_PRED, 8'hF8, 1'b0);
    add_byte_row(ROW_PRED, 8'h80, 1'b0);
    // Four-byte lead swallows a letter; the query ends inside the character.
    add_byte_row(ROW_PRED, 8'hF0, 1'b0);
    add_byte_row(ROW_PRED, 8'h41, 1'b0);
    add_byte_row(ROW_PRED, 8'hE4, 1'b1);
    // Widest range, and writes to indexes with no register.
    add_cfg_row(CFG_CJK_LOW, 16'h0800);
    add_cfg_row(CFG_CJK_HIGH, 16'hFFFF);
    add_cfg_row(CFG_NO_REG_2, 16'h1234);
    add_cfg_row(CFG_NO_REG_3, 16'hFFFF);
    // Overlong form, surrogate, and the top code point.
    add_byte_row(ROW_PRED, 8'hE0, 1'b0);
    add_byte_row(ROW_PRED, 8'h80, 1'b0);
    add_byte_row(ROW_PRED, 8'h80, 1'b0);
    add_byte_row(ROW_PRED, 8'hED, 1'b0);
    add_byte_row(ROW_PRED, 8'hA0, 1'b0);
    add_byte_row(ROW_PRED, 8'h80, 1'b0);
    add_byte_row(ROW_PRED, 8'hEF, 1'b0);
    add_byte_row(ROW_PRED, 8'hBF, 1'b0);
    add_byte_row(ROW_PRED, 8'hBF, 1'b1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        drain();
        set_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        push_byte(dir_tab[i].op, dir_tab[i].b, dir_tab[i].eoq, dir_tab[i].r);
      end
    end
    drain();

    // Widest range, no idling.
    run_queries(PHASE_ITEMS);
    drain();

    // Empty range at the extremes, sender idling.
    set_reg(CFG_CJK_LOW, 16'hFFFF);
    set_reg(CFG_CJK_HIGH, 16'h0800);
    send_idle_pct = 61;
    run_queries(PHASE_ITEMS);
    drain();

    // Default range, receiver stalling, with one long hold-off that fills the block.
    set_reg(CFG_CJK_LOW, CJK_LOW_RESET);
    set_reg(CFG_CJK_HIGH, CJK_HIGH_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    hold_req = 1'b1;
    run_queries(PHASE_ITEMS);
    drain();

    // Random range, both sides idling, with a pause until all tokens are out.
    set_reg(CFG_CJK_LOW, 16'($urandom_range(16'h0800, 16'hFFFF)));
    set_reg(CFG_CJK_HIGH, 16'($urandom_range(16'h0800, 16'hFFFF)));
    if (range_lo > range_hi && $urandom_range(3) != 0) begin
      set_reg(CFG_CJK_LOW, range_hi);
    end
    send_idle_pct = 27;
    recv_stall_pct = 27;
    run_queries(PHASE_ITEMS / 2);
    drain();
    run_queries(PHASE_ITEMS / 2);
    drain();

    // A single code point as the range, no idling.
    set_reg(CFG_CJK_LOW, 16'($urandom_range(16'h4E00, 16'h9FFF)));
    set_reg(CFG_CJK_HIGH, range_lo);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_queries(PHASE_ITEMS);
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
